### rtl/core/bob_pkg.sv
// ----------------------------------------------------------------------------
// bob_pkg
// Shared types and constants of the orbit histogram block.
// ----------------------------------------------------------------------------
package bob_pkg;
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [2:0] REG_MAX_ITER = 3'd0;
	localparam logic [2:0] REG_ESC_SQ   = 3'd1;
	localparam logic [2:0] REG_X_ORG    = 3'd2;
	localparam logic [2:0] REG_Y_ORG    = 3'd3;
	localparam logic [2:0] REG_X_SCALE  = 3'd4;
	localparam logic [2:0] REG_Y_SCALE  = 3'd5;
	localparam logic [2:0] REG_COLS     = 3'd6;
	localparam logic [2:0] REG_ROWS     = 3'd7;
endpackage

### rtl/core/bob_ram.sv
// ----------------------------------------------------------------------------
// bob_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/core/buddhabrot_orbit_histogram.sv
// ----------------------------------------------------------------------------
// buddhabrot_orbit_histogram
// Escape-orbit histogram engine with one shared multiplier.
// ----------------------------------------------------------------------------
// A sample item runs the escape loop with one 33x33 signed multiplier. The
// multiplier serves three products per iteration (zr*zr, zi*zi, zr*zi). Each
// iteration steps through M0, M1, M2, TEST and UPD, and the final escape test
// through M0, M1, M2 and TEST. If the point escaped, its orbit is then
// replayed. Each replay step recomputes z in M0, M1, M2 and UPD and forms the
// two bin products in BX and BY, checked in BCHK. When the point lands on the
// grid, the step ends with a read-modify-write of the histogram RAM in RD and
// WR. A read item passes through RD and RDCMD to OUT. After reset the
// histogram is cleared one entry a cycle, all 2**(2*clog2(GRID_SIZE))
// entries, 65536 at the default size. No item is accepted during the clear.
module buddhabrot_orbit_histogram #(
	parameter int GRID_SIZE  = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic signed [31:0] c_real,
	input  logic signed [31:0] c_imag,
	input  logic [7:0]  read_col,
	input  logic [7:0]  read_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        escaped,
	output logic [10:0] iteration_count,
	output logic [31:0] bin_value
);
	import bob_pkg::*;

	localparam int GB = $clog2(GRID_SIZE);
	localparam int AB = 2 * GB;
	localparam int DEPTH = 1 << AB;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_M0    = 14'b00000000000100,
		S_M1    = 14'b00000000001000,
		S_M2    = 14'b00000000010000,
		S_TEST  = 14'b00000000100000,
		S_UPD   = 14'b00000001000000,
		S_BX    = 14'b00000010000000,
		S_BY    = 14'b00000100000000,
		S_BCHK  = 14'b00001000000000,
		S_RD    = 14'b00010000000000,
		S_WR    = 14'b00100000000000,
		S_RDCMD = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [9:0]  iter_lim_q;
	logic [30:0] esc_sq_q;
	logic signed [31:0] x_org_q, y_org_q;
	logic [31:0] x_scale_q, y_scale_q;
	logic [8:0]  cols_q, rows_q;

	logic signed [31:0] cr_q, ci_q, zr_q, zi_q;
	logic signed [63:0] rr_q, ii_q, ri_q;
	logic [10:0] n_q, k_q;
	logic        replay_q;
	logic        esc_q;
	logic [31:0] bin_q;
	logic        rd_ok_q;
	logic [AB-1:0] addr_q;
	logic [GB-1:0] bc_q;
	logic        bx_ok_q;
	logic        by_ok_q;

	// Shared multiplier: operands chosen by state.
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic signed [32:0] dx, dy;
	logic [32:0] dmag;
	logic        dneg;

	assign dx = 33'(zr_q) - 33'(x_org_q);
	assign dy = 33'(zi_q) - 33'(y_org_q);

	always_comb begin
		ma = 33'(zr_q);
		mb = 33'(zr_q);
		dneg = 1'b0;
		dmag = '0;
		case (state_q)
			S_M1: begin
				ma = 33'(zi_q);
				mb = 33'(zi_q);
			end
			S_M2: begin
				ma = 33'(zr_q);
				mb = 33'(zi_q);
			end
			S_BX: begin
				dneg = dx[32];
				dmag = dneg ? 33'(-dx) : 33'(dx);
				ma = $signed({1'b0, dmag[31:0]});
				mb = $signed({1'b0, x_scale_q});
			end
			S_BY: begin
				dneg = dy[32];
				dmag = dneg ? 33'(-dy) : 33'(dy);
				ma = $signed({1'b0, dmag[31:0]});
				mb = $signed({1'b0, y_scale_q});
			end
			default: ;
		endcase
		mp = ma * mb;
	end

	// Bin product uses the full 33-bit magnitude; bit 32 set only for -2^32.
	logic [65:0] bq_full;
	logic [21:0] bq;
	logic [31:0] bscale;
	always_comb begin
		bscale = (state_q == S_BX) ? x_scale_q : y_scale_q;
		bq_full = dmag[32] ? {1'b0, bscale, 33'd0} : 66'(unsigned'(mp));
		bq = bq_full[65:44];
	end

	logic [31:0] climit, rlimit;
	assign climit = (32'(cols_q) > 32'(GRID_SIZE)) ? 32'(GRID_SIZE) : 32'(cols_q);
	assign rlimit = (32'(rows_q) > 32'(GRID_SIZE)) ? 32'(GRID_SIZE) : 32'(rows_q);

	logic bin_ok;
	always_comb begin
		if (dneg && bq != 0) bin_ok = 1'b0;
		else bin_ok = 32'(bq) < ((state_q == S_BX) ? climit : rlimit);
	end

	// z update from the three stored products.
	logic signed [64:0] dsq;
	logic signed [36:0] nr, ni;
	logic signed [31:0] nr_s, ni_s;
	always_comb begin
		dsq = 65'(rr_q) - 65'(ii_q);
		nr = 37'(dsq >>> 28) + 37'(cr_q);
		ni = 37'(ri_q >>> 27) + 37'(ci_q);
		nr_s = (nr > 37'sd2147483647) ? 32'sh7fffffff :
			(nr < -37'sd2147483648) ? 32'sh80000000 : nr[31:0];
		ni_s = (ni > 37'sd2147483647) ? 32'sh7fffffff :
			(ni < -37'sd2147483648) ? 32'sh80000000 : ni[31:0];
	end

	logic [64:0] magsq;
	logic        in_bounds;
	assign magsq = 65'(unsigned'(rr_q)) + 65'(unsigned'(ii_q));
	assign in_bounds = (magsq <= {6'd0, esc_sq_q, 28'd0}) && ({1'b0, n_q[9:0]} <=
		{1'b0, iter_lim_q} && !n_q[10]);

	logic            ram_we;
	logic [AB-1:0]   ram_addr;
	logic [COUNT_BITS-1:0] ram_wd, ram_rd;

	always_comb begin
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wd = (ram_rd == CMAX) ? ram_rd : ram_rd + 1'b1;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wd = '0;
			end
			S_WR: ram_we = 1'b1;
			default: ;
		endcase
	end

	bob_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wd),
		.rdata(ram_rd)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	function automatic logic esc_q_next(input logic [10:0] n, input logic [9:0] m);
		esc_q_next = n <= {1'b0, m};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_lim_q <= 10'd500;
			esc_sq_q <= 31'd1073741824;
			x_org_q <= -32'sd536870912;
			y_org_q <= -32'sd402653184;
			x_scale_q <= 32'd5592405;
			y_scale_q <= 32'd5592405;
			cols_q <= 9'd256;
			rows_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_ITER: iter_lim_q <= cfg_data[9:0];
				REG_ESC_SQ:   esc_sq_q <= cfg_data[30:0];
				REG_X_ORG:    x_org_q <= cfg_data;
				REG_Y_ORG:    y_org_q <= cfg_data;
				REG_X_SCALE:  x_scale_q <= cfg_data;
				REG_Y_SCALE:  y_scale_q <= cfg_data;
				REG_COLS:     cols_q <= cfg_data[8:0];
				REG_ROWS:     rows_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			replay_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AB'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					if (cmd == CMD_READ) begin
						addr_q <= {GB'(read_row), GB'(read_col)};
						state_q <= S_RD;
						replay_q <= 1'b0;
					end else begin
						replay_q <= 1'b0;
						state_q <= S_M0;
					end
				end
				S_M0: state_q <= S_M1;
				S_M1: state_q <= S_M2;
				S_M2: state_q <= replay_q ? S_UPD : S_TEST;
				S_TEST: begin
					if (in_bounds) state_q <= S_UPD;
					else if (esc_q_next(n_q, iter_lim_q)) state_q <= S_M0;
					else state_q <= S_OUT;
				end
				S_UPD: begin
					if (replay_q) state_q <= S_BX;
					else state_q <= S_M0;
				end
				S_BX: state_q <= S_BY;
				S_BY: state_q <= S_BCHK;
				S_BCHK: begin
					addr_q <= AB'({addr_q[GB-1:0], bc_q});
					if (bx_ok_q && by_ok_q) state_q <= S_RD;
					else if (k_q == n_q) state_q <= S_OUT;
					else state_q <= S_M0;
				end
				S_RD: state_q <= replay_q ? S_WR : S_RDCMD;
				S_WR: state_q <= (k_q == n_q) ? S_OUT : S_M0;
				S_RDCMD: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
					if (!out_ready && !replay_q && esc_q && bin_q == 0) state_q <= S_OUT;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_TEST && !in_bounds && esc_q_next(n_q, iter_lim_q)) begin
				replay_q <= 1'b1;
			end
			if (state_q == S_BY) addr_q <= AB'(bq[GB-1:0]);
		end
	end

	// Replay after escape restarts z at zero and counts k up to n.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) begin
				cr_q <= c_real;
				ci_q <= c_imag;
				zr_q <= '0;
				zi_q <= '0;
				n_q <= '0;
				k_q <= '0;
				esc_q <= 1'b0;
				bin_q <= '0;
				rd_ok_q <= (cmd == CMD_READ) && (32'(read_col) < 32'(GRID_SIZE)) &&
					(32'(read_row) < 32'(GRID_SIZE));
			end
			S_M0: rr_q <= mp[63:0];
			S_M1: ii_q <= mp[63:0];
			S_M2: ri_q <= mp[63:0];
			S_TEST: begin
				if (!in_bounds) begin
					esc_q <= esc_q_next(n_q, iter_lim_q);
					if (esc_q_next(n_q, iter_lim_q)) begin
						zr_q <= '0;
						zi_q <= '0;
					end
				end
			end
			S_UPD: begin
				zr_q <= nr_s;
				zi_q <= ni_s;
				if (replay_q) k_q <= k_q + 1'b1;
				else n_q <= n_q + 1'b1;
			end
			S_BX: begin
				bx_ok_q <= bin_ok;
				bc_q <= bq[GB-1:0];
			end
			S_BY: by_ok_q <= bin_ok;
			S_RDCMD: bin_q <= rd_ok_q ? 32'(ram_rd) : '0;
			S_RD: if (rd_ok_q) bin_q <= 32'(ram_rd);
			default: ;
		endcase
	end

	assign escaped = esc_q;
	assign iteration_count = rd_ok_q ? 11'd0 : n_q;
	assign bin_value = bin_q;
endmodule

### rtl/core/bob_checker.sv
// ----------------------------------------------------------------------------
// bob_checker
// Port-level checks of the orbit histogram block.
// ----------------------------------------------------------------------------
module bob_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        escaped,
	input logic [31:0] bin_value
);
	// The block holds one item at a time.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after an accepted item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_value))
		else $error("result dropped");

	a_excl_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> bin_value == 32'd0)
		else $error("sample result with bin value");
endmodule

bind buddhabrot_orbit_histogram bob_checker u_bob_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .escaped(escaped),
	.bin_value(bin_value)
);
